### sv/webp_header_dimension_parser_assert.svh
// Assertion macros shared by the parser's RTL.
`ifndef WEBP_HEADER_DIMENSION_PARSER_ASSERT_SVH
`define WEBP_HEADER_DIMENSION_PARSER_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define WPDP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define WPDP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

### sv/wpdp_pkg.sv
package wpdp_pkg;

  localparam int DimW      = 25;
  localparam int ChunkCntW = 8;
  localparam int CountW    = 4;
  localparam int NumFields = 12;
  localparam int SkipW     = 33;
  localparam int OutDataW  = 56;

  typedef logic [NumFields-1:0][7:0] fbytes_t;

  typedef enum logic [1:0] {
    ST_LOADED    = 2'd0,
    ST_NOT_RECOG = 2'd1,
    ST_ERROR     = 2'd2
  } status_t;

  typedef enum logic [0:0] {
    CFG_MAX_DIMENSION = 1'b0,
    CFG_MAX_CHUNKS    = 1'b1
  } cfg_index_t;

  typedef enum logic [4:0] {
    PH_HEADER  = 5'b00001,
    PH_CHUNK   = 5'b00010,
    PH_PAYLOAD = 5'b00100,
    PH_SKIP    = 5'b01000,
    PH_DONE    = 5'b10000
  } phase_t;

  typedef enum logic [1:0] {
    KIND_OTHER = 2'd0,
    KIND_VP8   = 2'd1,
    KIND_VP8L  = 2'd2,
    KIND_VP8X  = 2'd3
  } kind_t;

  // Four-character tags as they sit in the byte store, first character lowest.
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WEBP = 32'h5042_4557;
  localparam logic [31:0] TAG_VP8  = 32'h2038_5056;
  localparam logic [31:0] TAG_VP8L = 32'h4C38_5056;
  localparam logic [31:0] TAG_VP8X = 32'h5838_5056;

  localparam logic [7:0] VP8_SYNC0 = 8'h9D;
  localparam logic [7:0] VP8_SYNC1 = 8'h01;
  localparam logic [7:0] VP8_SYNC2 = 8'h2A;
  localparam logic [7:0] VP8L_SIG  = 8'h2F;

  localparam logic [CountW-1:0] HEADER_LEN    = 4'd12;
  localparam logic [CountW-1:0] CHUNK_HDR_LEN = 4'd8;
  localparam logic [CountW-1:0] NEED_VP8L     = 4'd5;
  localparam logic [CountW-1:0] NEED_OTHER    = 4'd10;

  localparam logic [DimW-1:0]      MAX_DIM_RESET    = 25'd1000000;
  localparam logic [ChunkCntW-1:0] MAX_CHUNKS_RESET = 8'd8;

  typedef struct packed {
    logic              en;
    logic [CountW-1:0] idx;
    logic [7:0]        data;
  } fwrite_t;

  typedef struct packed {
    logic            valid;
    status_t         status;
    logic [DimW-1:0] width;
    logic [DimW-1:0] height;
  } result_t;

endpackage

### sv/wpdp_fields.sv
// Twelve-byte store for header, chunk header and payload fields. The view
// shows the byte being written this cycle in place of the stored one.
module wpdp_fields (
  input  logic              clk,
  input  wpdp_pkg::fwrite_t wr,
  output wpdp_pkg::fbytes_t view
);

  wpdp_pkg::fbytes_t store;

  always_ff @(posedge clk) begin
    if (wr.en && (wr.idx < wpdp_pkg::CountW'(wpdp_pkg::NumFields))) begin
      store[wr.idx] <= wr.data;
    end
  end

  always_comb begin
    for (int i = 0; i < wpdp_pkg::NumFields; i++) begin
      if (wr.en && (wr.idx == wpdp_pkg::CountW'(i))) begin
        view[i] = wr.data;
      end else begin
        view[i] = store[i];
      end
    end
  end

endmodule

### sv/wpdp_parse.sv
// Container state machine: one byte per step, at most one result per step.
module wpdp_parse (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               step,
  input  logic [7:0]                         data_byte,
  input  logic                               end_of_file,
  input  wpdp_pkg::fbytes_t                  view,
  input  logic [wpdp_pkg::DimW-1:0]          max_dimension,
  input  logic [wpdp_pkg::ChunkCntW-1:0]     max_chunks,
  output wpdp_pkg::fwrite_t                  wr,
  output wpdp_pkg::result_t                  res
);

  wpdp_pkg::phase_t                   phase, phase_next;
  logic [wpdp_pkg::CountW-1:0]        count, count_next, count_inc;
  logic [wpdp_pkg::ChunkCntW-1:0]     chunks_seen, chunks_seen_next, seen_inc;
  wpdp_pkg::kind_t                    kind, kind_next, tag_kind;
  logic [wpdp_pkg::SkipW-1:0]         skip_remaining, skip_next, skip_len;
  logic [31:0]                        chunk_length;
  logic [wpdp_pkg::CountW-1:0]        need_tag, need_cur;
  logic                               sig_ok, give_up, have, rearm;
  wpdp_pkg::status_t                  status;
  logic                               pay_ok, pay_loaded;
  logic [wpdp_pkg::DimW-1:0]          pay_w, pay_h;
  logic [31:0]                        vp8l_bits;

  assign count_inc = count + 1'b1;
  assign seen_inc  = (chunks_seen == '1) ? chunks_seen : chunks_seen + 1'b1;
  assign give_up   = (seen_inc >= max_chunks);

  assign sig_ok = ({view[3], view[2], view[1], view[0]} == wpdp_pkg::TAG_RIFF) &&
                  ({view[11], view[10], view[9], view[8]} == wpdp_pkg::TAG_WEBP);

  assign chunk_length = {view[7], view[6], view[5], view[4]};
  assign skip_len = {1'b0, chunk_length} + {{(wpdp_pkg::SkipW-1){1'b0}}, chunk_length[0]};

  always_comb begin
    case ({view[3], view[2], view[1], view[0]})
      wpdp_pkg::TAG_VP8:  tag_kind = wpdp_pkg::KIND_VP8;
      wpdp_pkg::TAG_VP8L: tag_kind = wpdp_pkg::KIND_VP8L;
      wpdp_pkg::TAG_VP8X: tag_kind = wpdp_pkg::KIND_VP8X;
      default:            tag_kind = wpdp_pkg::KIND_OTHER;
    endcase
  end

  assign need_tag = (tag_kind == wpdp_pkg::KIND_VP8L) ? wpdp_pkg::NEED_VP8L
                                                      : wpdp_pkg::NEED_OTHER;
  assign need_cur = (kind == wpdp_pkg::KIND_VP8L) ? wpdp_pkg::NEED_VP8L
                                                  : wpdp_pkg::NEED_OTHER;

  // Picture size from the image chunk's leading bytes.
  assign vp8l_bits = {view[4], view[3], view[2], view[1]};

  always_comb begin
    case (kind)
      wpdp_pkg::KIND_VP8: begin
        pay_ok = (view[3] == wpdp_pkg::VP8_SYNC0) && (view[4] == wpdp_pkg::VP8_SYNC1) &&
                 (view[5] == wpdp_pkg::VP8_SYNC2);
        pay_w  = {11'd0, view[7][5:0], view[6]};
        pay_h  = {11'd0, view[9][5:0], view[8]};
      end
      wpdp_pkg::KIND_VP8L: begin
        pay_ok = (view[0] == wpdp_pkg::VP8L_SIG);
        pay_w  = {11'd0, vp8l_bits[13:0]} + 1'b1;
        pay_h  = {11'd0, vp8l_bits[27:14]} + 1'b1;
      end
      default: begin
        pay_ok = 1'b1;
        pay_w  = {1'b0, view[6], view[5], view[4]} + 1'b1;
        pay_h  = {1'b0, view[9], view[8], view[7]} + 1'b1;
      end
    endcase
  end

  assign pay_loaded = pay_ok && (pay_w != '0) && (pay_h != '0) &&
                      (pay_w <= max_dimension) && (pay_h <= max_dimension);

  assign wr.en   = step && (count < wpdp_pkg::HEADER_LEN) &&
                   ((phase == wpdp_pkg::PH_HEADER) || (phase == wpdp_pkg::PH_CHUNK) ||
                    (phase == wpdp_pkg::PH_PAYLOAD));
  assign wr.idx  = count;
  assign wr.data = data_byte;

  always_comb begin
    phase_next       = phase;
    count_next       = count;
    chunks_seen_next = chunks_seen;
    kind_next        = kind;
    skip_next        = skip_remaining;
    have             = 1'b0;
    rearm            = 1'b0;
    status           = wpdp_pkg::ST_ERROR;
    res.width        = '0;
    res.height       = '0;

    if (step) begin
      unique case (phase)
        wpdp_pkg::PH_HEADER: begin
          count_next = count_inc;
          if (count_inc >= wpdp_pkg::HEADER_LEN) begin
            if (sig_ok) begin
              phase_next       = wpdp_pkg::PH_CHUNK;
              count_next       = '0;
              chunks_seen_next = '0;
              have             = (max_chunks == '0);
            end else begin
              have   = 1'b1;
              status = wpdp_pkg::ST_NOT_RECOG;
            end
          end
        end
        wpdp_pkg::PH_CHUNK: begin
          count_next = count_inc;
          if (count_inc >= wpdp_pkg::CHUNK_HDR_LEN) begin
            count_next = '0;
            kind_next  = tag_kind;
            if (tag_kind == wpdp_pkg::KIND_OTHER) begin
              skip_next = skip_len;
              if (skip_len == '0) begin
                // Empty chunk: done as soon as its header is.
                chunks_seen_next = seen_inc;
                have             = give_up;
              end else begin
                phase_next = wpdp_pkg::PH_SKIP;
              end
            end else if (chunk_length < {28'd0, need_tag}) begin
              have = 1'b1;
            end else begin
              phase_next = wpdp_pkg::PH_PAYLOAD;
            end
          end
        end
        wpdp_pkg::PH_PAYLOAD: begin
          count_next = count_inc;
          if (count_inc >= need_cur) begin
            have = 1'b1;
            if (pay_loaded) begin
              status     = wpdp_pkg::ST_LOADED;
              res.width  = pay_w;
              res.height = pay_h;
            end
          end
        end
        wpdp_pkg::PH_SKIP: begin
          skip_next = skip_remaining - 1'b1;
          if (skip_remaining <= {{(wpdp_pkg::SkipW-1){1'b0}}, 1'b1}) begin
            skip_next        = '0;
            chunks_seen_next = seen_inc;
            if (give_up) begin
              have = 1'b1;
            end else begin
              phase_next = wpdp_pkg::PH_CHUNK;
              count_next = '0;
            end
          end
        end
        wpdp_pkg::PH_DONE: begin
          rearm = end_of_file;
        end
        default: begin
          rearm = 1'b1;
        end
      endcase

      // A file that ends early: not recognised inside the header, error after.
      if ((phase != wpdp_pkg::PH_DONE) && !have && end_of_file) begin
        have   = 1'b1;
        status = (phase_next == wpdp_pkg::PH_HEADER) ? wpdp_pkg::ST_NOT_RECOG
                                                    : wpdp_pkg::ST_ERROR;
      end
      if (have) begin
        if (end_of_file) begin
          rearm = 1'b1;
        end else begin
          phase_next = wpdp_pkg::PH_DONE;
        end
      end
    end

    if (rearm) begin
      phase_next       = wpdp_pkg::PH_HEADER;
      count_next       = '0;
      chunks_seen_next = '0;
      kind_next        = wpdp_pkg::KIND_OTHER;
      skip_next        = '0;
    end

    res.valid  = have;
    res.status = status;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= wpdp_pkg::PH_HEADER;
      count          <= '0;
      chunks_seen    <= '0;
      kind           <= wpdp_pkg::KIND_OTHER;
      skip_remaining <= '0;
    end else begin
      phase          <= phase_next;
      count          <= count_next;
      chunks_seen    <= chunks_seen_next;
      kind           <= kind_next;
      skip_remaining <= skip_next;
    end
  end

endmodule

### sv/wpdp_out.sv
// Result register on the master side; refills in the cycle it is drained.
module wpdp_out (
  input  logic                              clk,
  input  logic                              rst,
  input  wpdp_pkg::result_t                 res,
  input  logic                              step,
  output logic                              advance,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [wpdp_pkg::OutDataW-1:0]     m_tdata
);

  logic              load;
  wpdp_pkg::result_t held;

  assign advance = !m_tvalid || m_tready;
  assign load    = step && res.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  assign m_tdata = {4'd0, held.height, held.width, held.status};

endmodule

### sv/webp_header_dimension_parser.sv
// WebP header dimension parser. Feed a file one byte per word on the slave
// side, with tlast high on the file's last byte. The block checks the
// 12-byte RIFF/WEBP header, walks the chunk headers, skips unknown chunks
// at their even-padded length (fewer than max_chunks of them) and reads the
// picture size from the first "VP8 ", "VP8L" or "VP8X" chunk. It sends one
// result word per file: status 0 (loaded, with width and height), 1 (format
// not recognised: bad signature, or the file ends inside the header) or 2
// (any other error: short or corrupt image chunk, a size of zero or above
// max_dimension, too many chunks, or an early end after the header). Width
// and height read zero unless the status is 0. Bytes after the result are
// dropped until the file's last byte, which re-arms the parser; a file that
// ends before a result gets its result on that last byte. The block takes
// one byte every clock cycle for as long as the master side keeps up: a
// byte is held in the input register, is parsed by a single pass of
// state-machine logic and its result lands in the output register, from
// which the result word is offered. Configuration
// writes (index 0 max_dimension, index 1 max_chunks) are always accepted and
// belong between files, when no result is outstanding.
module webp_header_dimension_parser (
  input  logic                                 clk,
  input  logic                                 rst,
  // Byte stream in.
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [7:0]                           s_tdata,   // [7:0] data_byte
  input  logic                                 s_tlast,   // end_of_file
  // Result words out.
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // [1:0] status, [26:2] image_width, [51:27] image_height, [55:52] zero
  output logic [wpdp_pkg::OutDataW-1:0]        m_tdata,
  // Register writes.
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  wpdp_pkg::cfg_index_t                 cfg_index,
  input  logic [wpdp_pkg::DimW-1:0]            cfg_data
);

`include "webp_header_dimension_parser_assert.svh"

  logic [wpdp_pkg::DimW-1:0]       max_dimension;
  logic [wpdp_pkg::ChunkCntW-1:0]  max_chunks;

  // Input register: the byte being parsed this cycle.
  logic                            in_valid;
  logic [7:0]                      in_byte;
  logic                            in_eof;
  logic                            advance;
  logic                            step;

  wpdp_pkg::fwrite_t               wr;
  wpdp_pkg::fbytes_t               view;
  wpdp_pkg::result_t               res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_dimension <= wpdp_pkg::MAX_DIM_RESET;
      max_chunks    <= wpdp_pkg::MAX_CHUNKS_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        wpdp_pkg::CFG_MAX_DIMENSION: max_dimension <= cfg_data;
        wpdp_pkg::CFG_MAX_CHUNKS:    max_chunks    <= cfg_data[wpdp_pkg::ChunkCntW-1:0];
        default:                     max_chunks    <= max_chunks;
      endcase
    end
  end

  // The held byte moves on whenever the result register can take its
  // outcome, so a new byte is taken in the same cycle.
  assign step     = in_valid && advance;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_eof  <= s_tlast;
    end
  end

  wpdp_fields u_fields (
    .clk  (clk),
    .wr   (wr),
    .view (view)
  );

  wpdp_parse u_parse (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .data_byte     (in_byte),
    .end_of_file   (in_eof),
    .view          (view),
    .max_dimension (max_dimension),
    .max_chunks    (max_chunks),
    .wr            (wr),
    .res           (res)
  );

  wpdp_out u_out (
    .clk      (clk),
    .rst      (rst),
    .res      (res),
    .step     (step),
    .advance  (advance),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Only a loaded result carries a size.
  `WPDP_ASSERT_IMPLY(a_size_only_when_loaded, clk, rst,
    m_tvalid && (m_tdata[1:0] != wpdp_pkg::ST_LOADED),
    (m_tdata[26:2] == '0) && (m_tdata[51:27] == '0))
  // An empty result register never holds back the byte stream.
  `WPDP_ASSERT_IMPLY(a_ready_when_empty, clk, rst, !m_tvalid, s_tready)
  // A result word needs a byte in the input register the cycle before.
  `WPDP_ASSERT_NEXT(a_no_result_from_nothing, clk, rst,
    !m_tvalid && !in_valid, !m_tvalid)

endmodule
